### rtl/core/btff_pkg.sv
// Shared types, codes and constants for the block table first-fit allocator.
`default_nettype none

package btff_pkg;

    // Heap geometry
    localparam int BLOCK_BYTES    = 4096;
    localparam int BLOCK_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int MAX_BLOCKS_DEF = 1024;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int BASE_W     = 20;
    localparam int BIU_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(1024);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_RUN = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTES_W-1:0] alloc_bytes;
        logic [ADDR_W-1:0]  free_address;
    } t_alloc_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        logic [STATUS_W-1:0] status;
    } t_alloc_rsp;

    // One table entry
    typedef struct packed {
        logic has_next;
        logic first;
        logic taken;
    } t_marks;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_WALK,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

### rtl/core/btff_mark_table.sv
// Block mark table: one write port, one read port, registered read data.
`default_nettype none

module btff_mark_table #(
    parameter int DEPTH = btff_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output btff_pkg::t_marks                o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire btff_pkg::t_marks           i_wr_data
);
    import btff_pkg::*;

    t_marks r_marks [DEPTH];
    t_marks r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_marks[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_marks[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

    // The sequencer never reads the entry it writes in the same cycle
    a_no_collision: assert property (@(posedge i_clk)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("mark table read and write hit the same entry");

endmodule

`default_nettype wire

### rtl/core/block_table_first_fit_allocator_core.sv
// Top level of the block table first-fit heap allocator.
//
// Channels: a request channel (i_in_valid / o_in_stall / i_in_data) carries
// command, alloc_bytes and free_address; a response channel (o_out_valid /
// i_out_stall / o_out_data) returns one transaction per request with
// block_address and status. A transaction moves on an edge where valid is
// high and stall is low. The configuration channel (i_cfg_valid /
// o_cfg_ready / i_cfg_index / i_cfg_data) writes heap_base_block (index 0)
// and blocks_in_use (index 1); write it only while no request is in flight.
//
// Request handling, with N the usable table size:
//   allocate : decode, a scan of at most N entries, one write per block
//   free     : decode, a read of the first block, then a has-next chain walk
//   clear    : decode, then all MAX_BLOCKS table entries written free
//   rejected : decode, then the response
// The mark table has one read port and one write port; one table entry
// is visited per cycle. One request is worked on at a time; the next
// request is taken while an earlier response still waits in the output
// register.
// Reset: a clearing pass writes every table entry free, one per cycle,
// while requests are stalled; configuration writes are taken throughout.
// A stalled response holds in the output register and the block finishes
// the next request but holds its result until it drains.
`default_nettype none

module block_table_first_fit_allocator_core #(
    parameter int MAX_BLOCKS = btff_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire btff_pkg::t_alloc_req             i_in_data,
    // response
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output btff_pkg::t_alloc_rsp                  o_out_data,
    // configuration
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [btff_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [btff_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import btff_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    // state and control
    t_state             r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_chk_idx, n_chk_idx;
    logic               r_pend, n_pend;
    logic               r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    // payload
    t_alloc_req         r_req, n_req;
    logic [CW-1:0]      r_run, n_run;
    logic [CW-1:0]      r_start, n_start;
    logic [CW-1:0]      r_need, n_need;
    logic [CW-1:0]      r_left, n_left;
    t_alloc_rsp         r_res, n_res;
    t_alloc_rsp         r_out, n_out;
    // configuration
    logic [BASE_W-1:0]  r_base;
    logic [BIU_W-1:0]   r_biu;

    // table ports
    logic               tbl_rd_en;
    logic [AW-1:0]      tbl_rd_addr;
    t_marks             tbl_rd_data;
    logic               tbl_wr_en;
    logic [AW-1:0]      tbl_wr_addr;
    t_marks             tbl_wr_data;

    // decode helpers
    logic [31:0]        total32;
    logic [CW-1:0]      total;
    logic [32:0]        need33;
    logic [31:0]        base_addr;
    logic [31:0]        free_off;
    logic [31:0]        free_blk;
    logic [31:0]        alloc_blk;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      chk_inc;
    logic [CW-1:0]      run_inc;

    btff_mark_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (tbl_rd_addr),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data)
    );

    // Usable table size: blocks_in_use saturated at the table depth
    assign total32 = (32'(r_biu) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS) : 32'(r_biu);
    assign total   = total32[CW-1:0];

    // Round the byte count up to whole blocks
    assign need33    = ({1'b0, r_req.alloc_bytes} + 33'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
    assign base_addr = 32'(r_base) << BLOCK_SHIFT;
    assign free_off  = r_req.free_address - base_addr;
    assign free_blk  = free_off >> BLOCK_SHIFT;
    // Start address wraps modulo 2^32
    assign alloc_blk = 32'(r_base) + 32'(r_start);

    assign idx_inc = r_idx + CW'(1);
    assign chk_inc = r_chk_idx + CW'(1);
    assign run_inc = r_run + CW'(1);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_biu  <= BIU_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HEAP_BASE) begin
                r_base <= i_cfg_data[BASE_W-1:0];
            end else if (i_cfg_index == CFG_BLOCKS_IN_USE) begin
                r_biu <= i_cfg_data[BIU_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_chk_idx   <= '0;
            r_pend      <= 1'b0;
            r_clr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_chk_idx   <= n_chk_idx;
            r_pend      <= n_pend;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_run   <= n_run;
        r_start <= n_start;
        r_need  <= n_need;
        r_left  <= n_left;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_chk_idx   = r_chk_idx;
        n_pend      = r_pend;
        n_clr       = r_clr;
        n_req       = r_req;
        n_run       = r_run;
        n_start     = r_start;
        n_need      = r_need;
        n_left      = r_left;
        n_res       = r_res;
        n_out       = r_out;
        // drain the output register when the receiver takes it
        n_out_valid = r_out_valid && i_out_stall;

        tbl_rd_en   = 1'b0;
        tbl_rd_addr = r_idx[AW-1:0];
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = r_idx[AW-1:0];
        tbl_wr_data = '0;

        unique case (r_state)
            ST_CLEAR: begin
                // write every entry free, one per cycle
                tbl_wr_en = 1'b1;
                n_idx     = idx_inc;
                if (r_idx == CW'(MAX_BLOCKS - 1)) begin
                    n_idx = '0;
                    if (r_clr) begin
                        n_res   = '{block_address: '0, status: STAT_OK};
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_IDLE;
                    end
                    n_clr = 1'b0;
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_idx  = '0;
                n_pend = 1'b0;
                n_run  = '0;
                n_res  = '{block_address: '0, status: STAT_BAD};
                priority if (r_req.command == CMD_ALLOC) begin
                    priority if (need33 == '0) begin
                        n_state = ST_RESP;
                    end else if (need33 > 33'(total)) begin
                        n_res.status = STAT_NO_RUN;
                        n_state      = ST_RESP;
                    end else begin
                        n_need  = need33[CW-1:0];
                        n_state = ST_SCAN;
                    end
                end else if (r_req.command == CMD_FREE) begin
                    priority if (r_req.free_address < base_addr) begin
                        n_state = ST_RESP;
                    end else if (free_blk >= total32) begin
                        n_state = ST_RESP;
                    end else begin
                        n_idx   = free_blk[CW-1:0];
                        n_state = ST_FREE_RD;
                    end
                end else if (r_req.command == CMD_CLEAR) begin
                    n_clr   = 1'b1;
                    n_state = ST_CLEAR;
                end else begin
                    n_state = ST_RESP;
                end
            end

            ST_SCAN: begin
                // issue the next read while checking the previous entry
                tbl_rd_en = (r_idx < total);
                n_pend    = tbl_rd_en;
                n_chk_idx = r_idx;
                if (tbl_rd_en) begin
                    n_idx = idx_inc;
                end
                if (r_pend) begin
                    if (tbl_rd_data.taken) begin
                        n_run = '0;
                    end else begin
                        if (r_run == '0) begin
                            n_start = r_chk_idx;
                        end
                        n_run = run_inc;
                    end
                    priority if (!tbl_rd_data.taken && run_inc == r_need) begin
                        // run long enough: mark it from its first block
                        n_idx   = (r_run == '0) ? r_chk_idx : r_start;
                        n_left  = r_need;
                        n_pend  = 1'b0;
                        n_state = ST_MARK;
                    end else if (chk_inc == total) begin
                        n_res   = '{block_address: '0, status: STAT_NO_RUN};
                        n_pend  = 1'b0;
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_MARK: begin
                tbl_wr_en            = 1'b1;
                tbl_wr_data.taken    = 1'b1;
                tbl_wr_data.first    = (r_left == r_need);
                tbl_wr_data.has_next = (r_left != CW'(1));
                n_idx  = idx_inc;
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_res   = '{block_address: alloc_blk << BLOCK_SHIFT, status: STAT_OK};
                    n_state = ST_RESP;
                end
            end

            ST_FREE_RD: begin
                tbl_rd_en = 1'b1;
                n_state   = ST_FREE_WALK;
            end

            ST_FREE_WALK: begin
                // clear this entry; follow has-next inside the usable table
                tbl_wr_en = 1'b1;
                if (tbl_rd_data.has_next && idx_inc < total) begin
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = idx_inc[AW-1:0];
                    n_idx       = idx_inc;
                end else begin
                    n_res   = '{block_address: '0, status: STAT_OK};
                    n_state = ST_RESP;
                end
            end

            ST_RESP: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Failed and non-allocate responses carry a zero address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STAT_OK || o_out_data.block_address == '0))
        else $error("failed response carries a nonzero address");

    // Marking stays inside the usable table and always has blocks left
    a_mark_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK) |-> (r_left != '0 && r_idx < total))
        else $error("run marking out of bounds");

    // An entry under check during the scan lies inside the usable table
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN && r_chk_idx < total))
        else $error("scan checks an entry outside the table");

    // The chain walk always follows a table read
    a_walk_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FREE_WALK) |-> $past(tbl_rd_en))
        else $error("chain walk without read data");

endmodule

`default_nettype wire
